>>> hw/rtl/affa_pkg.sv
// Package: shared types, constants and command/status structs of the allocator.
package affa_pkg;

  localparam int unsigned MaxRegionsDefault = 64;
  localparam logic [31:0] PoolReset = 32'd268435456;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    DIV_ROUND = 3'd0,  // ceil(e/align)*align, absolute
    DIV_PAST  = 3'd1,  // pos + ((e-pos)/align+1)*align
    DIV_UPTO  = 3'd2   // pos + ceil((s-pos)/align)*align
  } div_mode_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request fields; walk position starts at 0, or at the release offset
    logic scan_start; // restart the slot scan
    logic scan_step;  // examine one slot
    logic div_start;  // start a step computation from the scan result
    logic write_slot; // record new region at free slot
    logic kill_slot;  // clear live bit of the matched slot
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_release;
    logic bad_size;
    logic scan_done;
    logic have_free;
    logic at_found;   // a region starts at pos
    logic hit_found;  // some region overlaps the candidate
    logic pos_end;    // pos >= pool
    logic last_out;   // pos+size-1 >= pool
    logic div_done;
  } dp_stat_t;

endpackage

>>> hw/rtl/affa_divider.sv
// Iterative 64-bit by 33-bit restoring divider, one quotient bit per cycle.
module affa_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import affa_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] sh;

  assign sh = {rem_r[32:0], q_r[63]};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

>>> hw/rtl/affa_datapath.sv
// Datapath: region table, slot scan, walk position and step arithmetic.
module affa_datapath #(
  parameter int unsigned MAX_REGIONS = affa_pkg::MaxRegionsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  input  logic              in_func,
  input  logic [31:0]       in_req_size,
  input  logic [31:0]       in_req_align,
  input  logic [31:0]       in_release_offset,
  input  affa_pkg::dp_cmd_t cmd,
  output affa_pkg::dp_stat_t stat,
  output logic [31:0]       pos_out
);
  import affa_pkg::*;

  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

  logic [31:0] start_mem [MAX_REGIONS];
  logic [31:0] len_mem   [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] live_r;

  logic [31:0] pool_r;
  logic        func_r;
  logic [31:0] size_r, align_r;
  logic [32:0] pos_r;           // walk position; step results are clamped to the pool end
  logic [CW-1:0] cnt_r;
  logic          scan_done_r;
  logic [IW-1:0] free_r, at_r;
  logic          have_free_r, at_found_r, hit_found_r;
  logic [31:0]   at_s_r, at_l_r, hit_s_r, hit_l_r;
  logic [31:0]   rd_s_r, rd_l_r;
  logic          rd_live_r, rd_v_r;
  logic [IW-1:0] rd_i_r;

  logic [32:0] align_x;
  assign align_x = (align_r == 32'd0) ? 33'd1 : {1'b0, align_r};

  // candidate window
  logic [33:0] last_w;
  assign last_w = {1'b0, pos_r} + {2'b0, size_r} - 34'd1;

  // read memory one slot a cycle, compare the slot registered
  logic [32:0] rd_e;
  logic rd_at, rd_hit;
  assign rd_e  = {1'b0, rd_s_r} + {1'b0, rd_l_r} - 33'd1;
  assign rd_at = rd_live_r && ({1'b0, rd_s_r} == pos_r);
  assign rd_hit = rd_live_r && (pos_r <= rd_e) && ({2'b0, rd_s_r} <= last_w);

  // step divider
  logic        div_start;
  logic [63:0] div_num;
  logic        div_done;
  logic [63:0] div_q;
  div_mode_t   mode_r;
  logic [32:0] hit_e;
  logic [32:0] at_e;
  assign hit_e = {1'b0, hit_s_r} + {1'b0, hit_l_r} - 33'd1;
  assign at_e  = {1'b0, at_s_r} + {1'b0, at_l_r};

  always_comb begin
    div_num = '0;
    if (at_found_r)
      div_num = {31'b0, at_e} + {31'b0, align_x} - 64'd1;
    else if ({1'b0, hit_s_r} <= pos_r)
      div_num = {31'b0, hit_e - pos_r};
    else
      div_num = {31'b0, {1'b0, hit_s_r} - pos_r} + {31'b0, align_x} - 64'd1;
  end
  assign div_start = cmd.div_start;

  affa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
    .divisor(align_x), .done(div_done), .quotient(div_q)
  );

  // quotient stays small once pos is bounded; keep the product narrow
  logic [32:0] q_lim;
  logic [65:0] prod;
  logic [33:0] new_pos;
  assign q_lim = (div_q[63:33] != '0) ? '1 : div_q[32:0];
  assign prod  = q_lim * align_x;

  always_comb begin
    case (mode_r)
      DIV_ROUND: new_pos = (prod[65:33] != '0) ? '1 : {1'b0, prod[32:0]};
      DIV_PAST: new_pos = (prod[65:33] != '0) ? '1
                          : {1'b0, pos_r} + {1'b0, prod[32:0]} + {1'b0, align_x};
      DIV_UPTO: new_pos = (prod[65:33] != '0) ? '1
                          : {1'b0, pos_r} + {1'b0, prod[32:0]};
      default:  new_pos = '1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= PoolReset;
      live_r      <= '0;
      cnt_r       <= '0;
      scan_done_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      if (cfg_valid) pool_r <= cfg_data;
      if (cmd.write_slot) live_r[free_r] <= 1'b1;
      if (cmd.kill_slot)  live_r[at_r]   <= 1'b0;
      rd_v_r <= 1'b0;
      if (cmd.scan_start) begin
        cnt_r       <= '0;
        scan_done_r <= 1'b0;
      end else if (cmd.scan_step && !scan_done_r) begin
        if (cnt_r < CW'(MAX_REGIONS)) begin
          rd_v_r <= 1'b1;
          cnt_r  <= cnt_r + CW'(1);
        end else if (!rd_v_r) begin
          scan_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_slot) begin
      start_mem[free_r] <= pos_r[31:0];
      len_mem[free_r]   <= size_r;
    end
    if (cmd.scan_step && cnt_r < CW'(MAX_REGIONS)) begin
      rd_s_r <= start_mem[cnt_r[IW-1:0]];
      rd_l_r <= len_mem[cnt_r[IW-1:0]];
      rd_live_r <= live_r[cnt_r[IW-1:0]];
      rd_i_r <= cnt_r[IW-1:0];
    end
    if (cmd.load) begin
      func_r  <= in_func;
      size_r  <= in_req_size;
      align_r <= in_req_align;
      pos_r   <= (in_func == FUNC_RELEASE) ? {1'b0, in_release_offset} : '0;
      have_free_r <= 1'b0;
    end
    if (cmd.scan_start) begin
      at_found_r  <= 1'b0;
      hit_found_r <= 1'b0;
    end else if (rd_v_r) begin
      if (!rd_live_r && !have_free_r) begin
        have_free_r <= 1'b1;
        free_r <= rd_i_r;
      end
      if (rd_at && !at_found_r) begin
        at_found_r <= 1'b1;
        at_r   <= rd_i_r;
        at_s_r <= rd_s_r;
        at_l_r <= rd_l_r;
      end
      if (rd_hit && (!hit_found_r || rd_s_r < hit_s_r)) begin
        hit_found_r <= 1'b1;
        hit_s_r <= rd_s_r;
        hit_l_r <= rd_l_r;
      end
    end
    if (cmd.div_start) begin
      if (at_found_r) mode_r <= DIV_ROUND;
      else if ({1'b0, hit_s_r} <= pos_r) mode_r <= DIV_PAST;
      else mode_r <= DIV_UPTO;
    end
    if (div_done)
      pos_r <= (new_pos[33] || new_pos[32:0] > {1'b0, pool_r}) ? {1'b0, pool_r}
               : new_pos[32:0];
  end

  assign stat.is_release = func_r;
  assign stat.bad_size   = (size_r == 32'd0) || (size_r > pool_r);
  assign stat.scan_done  = scan_done_r;
  assign stat.have_free  = have_free_r;
  assign stat.at_found   = at_found_r;
  assign stat.hit_found  = hit_found_r;
  assign stat.pos_end    = pos_r >= {1'b0, pool_r};
  assign stat.last_out   = last_w >= {2'b0, pool_r};
  assign stat.div_done   = div_done;
  assign pos_out         = pos_r[31:0];
endmodule

>>> hw/rtl/affa_ctrl.sv
// Controller: sequences scans, steps and the result register.
module affa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               res_success,
  output logic [1:0]         res_status,
  output logic               res_use_pos,
  output affa_pkg::dp_cmd_t  cmd,
  input  affa_pkg::dp_stat_t stat
);
  import affa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic first_r, first_nxt;
  logic succ_r, succ_nxt, use_r, use_nxt;
  logic [1:0] st_r, st_nxt;

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    succ_nxt = succ_r;
    st_nxt = st_r;
    use_nxt = use_r;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.is_release && stat.bad_size) begin
          succ_nxt = 1'b0; st_nxt = ST_NO_SPACE; use_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          cmd.scan_start = 1'b1;
          first_nxt = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        first_nxt = 1'b0;
        use_nxt = 1'b0;
        if (stat.is_release) begin
          if (stat.at_found) begin
            cmd.kill_slot = 1'b1;
            succ_nxt = 1'b1; st_nxt = ST_OK;
          end else begin
            succ_nxt = 1'b0; st_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_OUT;
        end else if (first_r && !stat.have_free) begin
          succ_nxt = 1'b0; st_nxt = ST_FULL; state_nxt = S_OUT;
        end else if (stat.pos_end) begin
          succ_nxt = 1'b0; st_nxt = ST_NO_SPACE; state_nxt = S_OUT;
        end else if (stat.at_found) begin
          cmd.div_start = 1'b1; state_nxt = S_DIV;
        end else if (stat.last_out) begin
          succ_nxt = 1'b0; st_nxt = ST_NO_SPACE; state_nxt = S_OUT;
        end else if (!stat.hit_found) begin
          cmd.write_slot = 1'b1;
          succ_nxt = 1'b1; st_nxt = ST_OK; use_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1; state_nxt = S_DIV;
        end
      end
      S_DIV: state_nxt = S_WAIT;
      S_WAIT: if (stat.div_done) begin
        state_nxt = S_WAIT;
        cmd.scan_start = 1'b1;
        state_nxt = S_SCAN;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
    succ_r <= succ_nxt;
    st_r   <= st_nxt;
    use_r  <= use_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign res_success = succ_r;
  assign res_status  = st_r;
  assign res_use_pos = use_r;
endmodule

>>> hw/rtl/aligned_first_fit_allocator_core.sv
// Top level: aligned first-fit region allocator core.
// Usage:
//  - in_valid/in_ready take one request: in_func 0 allocates in_req_size bytes
//    at alignment in_req_align (0 means 1); in_func 1 releases the region that
//    starts at in_release_offset.
//  - out_valid/out_ready return one result per request: out_success,
//    out_alloc_offset (granted offset, else 0) and out_status.
//  - cfg_valid/cfg_ready write pool_size; write only while idle.
// Each walk step is one slot scan plus, when the walk moves, a bit-serial
// division for the alignment step.
// One request is processed at a time; the next is taken once the result is
// accepted. A stalled receiver holds the result and blocks new requests.
// Reset clears all live bits and sets pool_size to 268435456; region
// offsets and lengths need no clearing.
module aligned_first_fit_allocator_core #(
  parameter int unsigned MAX_REGIONS = affa_pkg::MaxRegionsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_req_align,
  input  logic [31:0] in_release_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_success,
  output logic [31:0] out_alloc_offset,
  output logic [1:0]  out_status
);
  import affa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [31:0] pos;
  logic use_pos;

  assign cfg_ready = 1'b1;

  affa_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .in_func(in_func), .in_req_size(in_req_size), .in_req_align(in_req_align),
    .in_release_offset(in_release_offset), .cmd(cmd), .stat(stat),
    .pos_out(pos)
  );

  affa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .res_success(out_success),
    .res_status(out_status), .res_use_pos(use_pos), .cmd(cmd), .stat(stat)
  );

  assign out_alloc_offset = use_pos ? pos : 32'd0;
endmodule
